>>> hw/rtl/bsa_pkg.sv
// Shared types and constants for the bitmap slot allocator.
// Holds default sizes, field widths, operation, configuration and status codes and the controller state type.
// Depends on nothing; every allocator file imports it.
package bsa_pkg;

    localparam int MAX_OBJECTS_DEF = 1024;
    localparam int WORD_BITS_DEF   = 64;
    localparam int ADDR_BITS_DEF   = 48;

    localparam int BASE_BITS     = 48;
    localparam int SIZE_BITS     = 32;
    localparam int COUNT_BITS    = 11;
    localparam int SLOT_BITS     = 10;
    localparam int ACTION_BITS   = 2;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 48;

    localparam logic [ACTION_BITS-1:0] ACT_ALLOC   = 2'd0;
    localparam logic [ACTION_BITS-1:0] ACT_RESERVE = 2'd1;
    localparam logic [ACTION_BITS-1:0] ACT_FREE    = 2'd2;

    localparam logic [CFG_IDX_BITS-1:0] CFG_BASE  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SIZE  = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_COUNT = 2'd2;

    localparam logic [COUNT_BITS-1:0] COUNT_RESET = 11'd1024;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_NONE     = 3'd1,
        ST_RANGE    = 3'd2,
        ST_MISALIGN = 3'd3,
        ST_SAME     = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_SCAN,
        S_DIV,
        S_CHECK,
        S_RD,
        S_RMW,
        S_MUL,
        S_ADD,
        S_OUT
    } state_t;

endpackage

>>> hw/rtl/bitmap_slot_allocator_unit.sv
// Top level of the bitmap slot allocator: free bitmap memory, next-fit scan,
// address divider and result register. Depends on bsa_pkg.
//
// Channel | Direction | Handshake           | Payload
// input   | in        | in_valid / in_stall | action, slot_index, address
// output  | out       | out_valid/out_stall | status, slot_address, slot_number, in_use_count
// config  | in        | cfg_wr_en           | cfg_index, cfg_data
//
// An allocate scans at most W bitmap words, W being the number of words in use
// (16 at the default sizes); the scan reads one memory word per cycle.
// A reserve reads and rewrites one bitmap word. A free runs a divider that
// produces one quotient bit per cycle. After reset and after every write to the
// base, size or count setting, the bitmap is rebuilt one word per cycle, while
// no transaction is accepted.
// A finished result waits in the output register while the next transaction
// is accepted and processed; only the final result transfer waits for out_stall.
module bitmap_slot_allocator_unit
    import bsa_pkg::*;
#(
    parameter int MAX_OBJECTS = MAX_OBJECTS_DEF,
    parameter int WORD_BITS   = WORD_BITS_DEF,
    parameter int ADDR_BITS   = ADDR_BITS_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,

    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [ACTION_BITS-1:0]   action,
    input  logic [SLOT_BITS-1:0]     slot_index,
    input  logic [ADDR_BITS-1:0]     address,

    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [2:0]               status,
    output logic [ADDR_BITS-1:0]     slot_address,
    output logic [SLOT_BITS-1:0]     slot_number,
    output logic [COUNT_BITS-1:0]    in_use_count,

    input  logic                     cfg_wr_en,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data
);

    localparam int CAP_LIMIT  = (1 << COUNT_BITS) - 1;
    localparam int CAP        = (MAX_OBJECTS < CAP_LIMIT) ? MAX_OBJECTS : CAP_LIMIT;
    localparam int MEM_WORDS  = (CAP + WORD_BITS - 1) / WORD_BITS;
    localparam int WIDX_BITS  = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
    localparam int WCNT_BITS  = $clog2(MEM_WORDS + 1);
    localparam int BIT_BITS   = $clog2(WORD_BITS);
    localparam int DIVX_BITS  = COUNT_BITS + 1;
    localparam int RK         = DIVX_BITS + BIT_BITS + 1;
    localparam int RECIP      = ((1 << RK) + WORD_BITS - 1) / WORD_BITS;
    localparam int PROD_BITS  = COUNT_BITS + SIZE_BITS;
    localparam int EXT_A      = (ADDR_BITS > BASE_BITS) ? ADDR_BITS : BASE_BITS;
    localparam int EXT_BITS   = (EXT_A > PROD_BITS) ? EXT_A : PROD_BITS;
    localparam int DCNT_BITS  = $clog2(ADDR_BITS);

    // Quotient by the word size through a reciprocal; exact for every argument width used.
    function automatic logic [DIVX_BITS-1:0] word_quot(input logic [DIVX_BITS-1:0] x);
        logic [DIVX_BITS+RK-1:0] p;
        p = (DIVX_BITS+RK)'(x) * (DIVX_BITS+RK)'(RECIP);
        return DIVX_BITS'(p >> RK);
    endfunction

    state_t                  state_reg, state_next;
    logic [BASE_BITS-1:0]    base_reg, base_next;
    logic [SIZE_BITS-1:0]    size_reg, size_next;
    logic [COUNT_BITS-1:0]   count_reg, count_next;
    logic [WCNT_BITS-1:0]    init_w_reg, init_w_next;
    logic [WIDX_BITS-1:0]    last_word_reg, last_word_next;
    logic [COUNT_BITS-1:0]   used_reg, used_next;
    logic                    out_valid_reg, out_valid_next;
    logic                    rd_pending_reg;
    logic [WIDX_BITS-1:0]    scan_w_reg, scan_w_next;
    logic [WCNT_BITS-1:0]    issued_reg, issued_next;
    logic [DCNT_BITS-1:0]    div_cnt_reg, div_cnt_next;

    logic [ACTION_BITS-1:0]  action_reg, action_next;
    logic [ADDR_BITS-1:0]    addr_in_reg, addr_in_next;
    logic [ADDR_BITS-1:0]    dq_reg, dq_next;
    logic [SIZE_BITS-1:0]    rem_reg, rem_next;
    logic [COUNT_BITS-1:0]   slot_reg, slot_next;
    status_t                 res_status_reg, res_status_next;
    logic [ADDR_BITS-1:0]    res_addr_reg, res_addr_next;
    logic [PROD_BITS-1:0]    prod_reg, prod_next;
    logic [WIDX_BITS-1:0]    pend_w_reg, pend_w_next;

    status_t                 out_status_reg;
    logic [ADDR_BITS-1:0]    out_addr_reg;
    logic [SLOT_BITS-1:0]    out_slot_reg;
    logic [COUNT_BITS-1:0]   out_count_reg;
    logic                    load_out;

    logic [WORD_BITS-1:0]    mem [MEM_WORDS];
    logic [WORD_BITS-1:0]    rd_data_reg;
    logic                    mem_rd_en;
    logic [WIDX_BITS-1:0]    mem_rd_addr;
    logic                    mem_wr_en;
    logic [WIDX_BITS-1:0]    mem_wr_addr;
    logic [WORD_BITS-1:0]    mem_wr_data;

    logic [COUNT_BITS-1:0]   n_slots;
    logic [DIVX_BITS-1:0]    n_plus;
    logic [WCNT_BITS-1:0]    words;
    logic [SIZE_BITS-1:0]    stride;
    logic [DIVX_BITS-1:0]    init_lo;
    logic [WORD_BITS-1:0]    init_word;
    logic [WORD_BITS-1:0]    low_onehot;
    logic [BIT_BITS-1:0]     low_bit;
    logic                    found;
    logic [DIVX_BITS-1:0]    slot_q;
    logic [DIVX_BITS-1:0]    slot_rem;
    logic [WIDX_BITS-1:0]    slot_w;
    logic [WORD_BITS-1:0]    slot_onehot;
    logic [EXT_BITS-1:0]     addr_ext;
    logic [EXT_BITS-1:0]     base_ext;
    logic [SIZE_BITS:0]      div_shift;
    logic                    div_ge;

    assign n_slots = (count_reg > COUNT_BITS'(CAP)) ? COUNT_BITS'(CAP) : count_reg;
    assign n_plus  = DIVX_BITS'(n_slots) + DIVX_BITS'(WORD_BITS - 1);
    assign words   = WCNT_BITS'(word_quot(n_plus));
    assign stride  = (size_reg == '0) ? SIZE_BITS'(1) : size_reg;

    assign init_lo = DIVX_BITS'(DIVX_BITS'(init_w_reg) * DIVX_BITS'(WORD_BITS));

    always_comb
    begin
        for (int b = 0; b < WORD_BITS; b++)
        begin
            init_word[b] = (init_lo + DIVX_BITS'(b)) < DIVX_BITS'(n_slots);
        end
    end

    assign found      = rd_pending_reg && (rd_data_reg != '0);
    assign low_onehot = rd_data_reg & (~rd_data_reg + WORD_BITS'(1));

    always_comb
    begin
        low_bit = '0;
        for (int b = 0; b < WORD_BITS; b++)
        begin
            if (low_onehot[b])
            begin
                low_bit = low_bit | BIT_BITS'(b);
            end
        end
    end

    assign slot_q      = word_quot(DIVX_BITS'(slot_reg));
    assign slot_rem    = DIVX_BITS'(slot_reg) - DIVX_BITS'(slot_q * DIVX_BITS'(WORD_BITS));
    assign slot_w      = WIDX_BITS'(slot_q);
    assign slot_onehot = WORD_BITS'(1) << BIT_BITS'(slot_rem);

    assign addr_ext = EXT_BITS'(address);
    assign base_ext = EXT_BITS'(base_reg);

    assign div_shift = {rem_reg, dq_reg[ADDR_BITS-1]};
    assign div_ge    = div_shift >= {1'b0, stride};

    always_comb
    begin
        state_next      = state_reg;
        base_next       = base_reg;
        size_next       = size_reg;
        count_next      = count_reg;
        init_w_next     = init_w_reg;
        last_word_next  = last_word_reg;
        used_next       = used_reg;
        out_valid_next  = out_valid_reg;
        scan_w_next     = scan_w_reg;
        issued_next     = issued_reg;
        div_cnt_next    = div_cnt_reg;
        action_next     = action_reg;
        addr_in_next    = addr_in_reg;
        dq_next         = dq_reg;
        rem_next        = rem_reg;
        slot_next       = slot_reg;
        res_status_next = res_status_reg;
        res_addr_next   = res_addr_reg;
        prod_next       = prod_reg;
        pend_w_next     = pend_w_reg;
        in_stall        = 1'b1;
        load_out        = 1'b0;
        mem_rd_en       = 1'b0;
        mem_rd_addr     = scan_w_reg;
        mem_wr_en       = 1'b0;
        mem_wr_addr     = WIDX_BITS'(init_w_reg);
        mem_wr_data     = init_word;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_INIT:
            begin
                if (init_w_reg >= words)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    mem_wr_en   = 1'b1;
                    init_w_next = init_w_reg + WCNT_BITS'(1);
                end
            end
            S_IDLE:
            begin
                in_stall = cfg_wr_en;
                if (in_valid && !cfg_wr_en)
                begin
                    action_next     = action;
                    addr_in_next    = address;
                    res_status_next = ST_OK;
                    res_addr_next   = '0;
                    slot_next       = '0;
                    case (action)
                        ACT_ALLOC:
                        begin
                            if (words == '0)
                            begin
                                res_status_next = ST_NONE;
                                state_next      = S_OUT;
                            end
                            else
                            begin
                                scan_w_next = last_word_reg;
                                issued_next = '0;
                                state_next  = S_SCAN;
                            end
                        end
                        ACT_RESERVE:
                        begin
                            if (COUNT_BITS'(slot_index) >= n_slots)
                            begin
                                res_status_next = ST_RANGE;
                                state_next      = S_OUT;
                            end
                            else
                            begin
                                slot_next  = COUNT_BITS'(slot_index);
                                state_next = S_RD;
                            end
                        end
                        ACT_FREE:
                        begin
                            if (addr_ext < base_ext)
                            begin
                                res_status_next = ST_RANGE;
                                state_next      = S_OUT;
                            end
                            else
                            begin
                                dq_next      = ADDR_BITS'(addr_ext - base_ext);
                                rem_next     = '0;
                                div_cnt_next = '0;
                                state_next   = S_DIV;
                            end
                        end
                        default:
                        begin
                            state_next = S_OUT;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (found)
                begin
                    mem_wr_en      = 1'b1;
                    mem_wr_addr    = pend_w_reg;
                    mem_wr_data    = rd_data_reg & ~low_onehot;
                    slot_next      = COUNT_BITS'(COUNT_BITS'(pend_w_reg) * COUNT_BITS'(WORD_BITS)
                                     + COUNT_BITS'(low_bit));
                    last_word_next = pend_w_reg;
                    used_next      = used_reg + COUNT_BITS'(1);
                    state_next     = S_MUL;
                end
                else if (issued_reg < words)
                begin
                    mem_rd_en   = 1'b1;
                    pend_w_next = scan_w_reg;
                    issued_next = issued_reg + WCNT_BITS'(1);
                    if (WCNT_BITS'(scan_w_reg) + WCNT_BITS'(1) == words)
                    begin
                        scan_w_next = '0;
                    end
                    else
                    begin
                        scan_w_next = scan_w_reg + WIDX_BITS'(1);
                    end
                end
                else
                begin
                    res_status_next = ST_NONE;
                    slot_next       = '0;
                    state_next      = S_OUT;
                end
            end
            S_DIV:
            begin
                rem_next     = div_ge ? SIZE_BITS'(div_shift - {1'b0, stride})
                                      : SIZE_BITS'(div_shift);
                dq_next      = {dq_reg[ADDR_BITS-2:0], div_ge};
                div_cnt_next = div_cnt_reg + DCNT_BITS'(1);
                if (div_cnt_reg == DCNT_BITS'(ADDR_BITS - 1))
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (rem_reg != '0)
                begin
                    res_status_next = ST_MISALIGN;
                    state_next      = S_OUT;
                end
                else if (dq_reg >= ADDR_BITS'(n_slots))
                begin
                    res_status_next = ST_RANGE;
                    state_next      = S_OUT;
                end
                else
                begin
                    slot_next  = COUNT_BITS'(dq_reg);
                    state_next = S_RD;
                end
            end
            S_RD:
            begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = slot_w;
                state_next  = S_RMW;
            end
            S_RMW:
            begin
                mem_wr_addr = slot_w;
                if (action_reg == ACT_FREE)
                begin
                    if ((rd_data_reg & slot_onehot) != '0)
                    begin
                        res_status_next = ST_SAME;
                    end
                    else
                    begin
                        mem_wr_en     = 1'b1;
                        mem_wr_data   = rd_data_reg | slot_onehot;
                        res_addr_next = addr_in_reg;
                        if (used_reg != '0)
                        begin
                            used_next = used_reg - COUNT_BITS'(1);
                        end
                    end
                    state_next = S_OUT;
                end
                else
                begin
                    if ((rd_data_reg & slot_onehot) == '0)
                    begin
                        res_status_next = ST_SAME;
                        state_next      = S_OUT;
                    end
                    else
                    begin
                        mem_wr_en   = 1'b1;
                        mem_wr_data = rd_data_reg & ~slot_onehot;
                        used_next   = used_reg + COUNT_BITS'(1);
                        state_next  = S_MUL;
                    end
                end
            end
            S_MUL:
            begin
                prod_next  = PROD_BITS'(slot_reg) * PROD_BITS'(stride);
                state_next = S_ADD;
            end
            S_ADD:
            begin
                res_addr_next = ADDR_BITS'(base_ext + EXT_BITS'(prod_reg));
                state_next    = S_OUT;
            end
            S_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    load_out       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_INIT;
            end
        endcase

        if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_BASE:
                begin
                    base_next = cfg_data[BASE_BITS-1:0];
                end
                CFG_SIZE:
                begin
                    size_next = cfg_data[SIZE_BITS-1:0];
                end
                CFG_COUNT:
                begin
                    count_next = cfg_data[COUNT_BITS-1:0];
                end
                default:
                begin
                end
            endcase
            if (cfg_index == CFG_BASE || cfg_index == CFG_SIZE || cfg_index == CFG_COUNT)
            begin
                state_next     = S_INIT;
                init_w_next    = '0;
                last_word_next = '0;
                used_next      = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_INIT;
            base_reg       <= '0;
            size_reg       <= SIZE_BITS'(1);
            count_reg      <= COUNT_RESET;
            init_w_reg     <= '0;
            last_word_reg  <= '0;
            used_reg       <= '0;
            out_valid_reg  <= 1'b0;
            rd_pending_reg <= 1'b0;
            scan_w_reg     <= '0;
            issued_reg     <= '0;
            div_cnt_reg    <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            base_reg       <= base_next;
            size_reg       <= size_next;
            count_reg      <= count_next;
            init_w_reg     <= init_w_next;
            last_word_reg  <= last_word_next;
            used_reg       <= used_next;
            out_valid_reg  <= out_valid_next;
            rd_pending_reg <= mem_rd_en;
            scan_w_reg     <= scan_w_next;
            issued_reg     <= issued_next;
            div_cnt_reg    <= div_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        action_reg     <= action_next;
        addr_in_reg    <= addr_in_next;
        dq_reg         <= dq_next;
        rem_reg        <= rem_next;
        slot_reg       <= slot_next;
        res_status_reg <= res_status_next;
        res_addr_reg   <= res_addr_next;
        prod_reg       <= prod_next;
        pend_w_reg     <= pend_w_next;
        if (load_out)
        begin
            out_status_reg <= res_status_reg;
            out_addr_reg   <= res_addr_reg;
            out_slot_reg   <= SLOT_BITS'(slot_reg);
            out_count_reg  <= used_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_wr_en)
        begin
            mem[mem_wr_addr] <= mem_wr_data;
        end
        if (mem_rd_en)
        begin
            rd_data_reg <= mem[mem_rd_addr];
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = out_status_reg;
    assign slot_address = out_addr_reg;
    assign slot_number  = out_slot_reg;
    assign in_use_count = out_count_reg;

    // A read never meets a write to the same bitmap word in one cycle.
    a_no_rw_collision: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_rd_en && mem_wr_en) |-> (mem_rd_addr != mem_wr_addr))
        else $error("bitmap read and write hit the same word");

    // The in-use count never exceeds the number of managed slots.
    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= n_slots)
        else $error("in-use count exceeds managed slots");

    // Every failed operation reports a zero slot address.
    a_err_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_status_reg != ST_OK) |-> (out_addr_reg == '0))
        else $error("error result carries a nonzero address");

    // Transactions are taken only when the controller is idle.
    a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg != S_IDLE && state_reg != S_INIT))
        else $error("accepted transaction did not start processing");

endmodule
